@@ hw/rtl/minv_pkg.sv @@
`default_nettype none
package minv_pkg;
    localparam int unsigned WordW = 64;
    localparam int unsigned CntW  = 7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_STEP,
        ST_FIX,
        ST_DONE
    } state_t;
endpackage
`default_nettype wire

@@ hw/rtl/modular_inverse_euclid.sv @@
`default_nettype none
// Each value takes a sequence of Euclid steps on the bit-serial divide and cofactor unit;
// trivial values (zero, or not below the modulus) go straight to the fix-up state.
// Throughput: one item at a time; value_ready is high whenever the sequencer is idle.
// The output register lets the next value enter while a result still waits.
// Reset is asynchronous and active low; it clears the control state and sets modulus to 1.
module modular_inverse_euclid
    import minv_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [WordW-1:0] cfg_data,
    input  wire logic             value_valid,
    output logic                  value_ready,
    input  wire logic [WordW-1:0] value,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output logic [WordW-1:0]      inverse,
    output logic                  invertible
);
    state_t           state_reg, state_next;
    logic [WordW-1:0] modulus_reg;
    logic [WordW-1:0] rp_reg, rp_next, rc_reg, rc_next;
    logic [WordW-1:0] cp_reg, cp_next, cc_reg, cc_next;
    logic             pos_reg, pos_next;
    logic             ovalid_reg, ovalid_next;
    logic [WordW-1:0] inv_reg, inv_next;
    logic             ok_reg, ok_next;
    logic             div_start;
    logic             div_done;
    logic [WordW-1:0] div_rem, div_acc;

    minv_divmul u_divmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .a     (rp_reg),
        .b     (rc_reg),
        .c     (cp_reg),
        .d     (cc_reg),
        .done  (div_done),
        .rem   (div_rem),
        .acc   (div_acc)
    );

    assign value_ready = (state_reg == ST_IDLE);
    assign cfg_ready   = 1'b1;

    always_comb
    begin
        state_next  = state_reg;
        rp_next     = rp_reg;
        rc_next     = rc_reg;
        cp_next     = cp_reg;
        cc_next     = cc_reg;
        pos_next    = pos_reg;
        ovalid_next = ovalid_reg;
        inv_next    = inv_reg;
        ok_next     = ok_reg;
        div_start   = 1'b0;
        if (ovalid_reg && result_ready)
        begin
            ovalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (value_valid && value_ready)
                begin
                    rp_next  = modulus_reg;
                    rc_next  = value;
                    cp_next  = '0;
                    cc_next  = {{(WordW-1){1'b0}}, 1'b1};
                    pos_next = 1'b1;
                    if (value == '0 || value >= modulus_reg)
                    begin
                        rc_next    = '0;
                        state_next = ST_FIX;
                    end
                    else
                    begin
                        state_next = ST_STEP;
                    end
                end
            end
            ST_STEP:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (div_rem == '0)
                    begin
                        state_next = ST_FIX;
                    end
                    else
                    begin
                        rp_next    = rc_reg;
                        rc_next    = div_rem;
                        cp_next    = cc_reg;
                        cc_next    = div_acc;
                        pos_next   = !pos_reg;
                        state_next = ST_STEP;
                    end
                end
            end
            ST_FIX:
            begin
                if (!ovalid_reg || result_ready)
                begin
                    if (rc_reg == {{(WordW-1){1'b0}}, 1'b1})
                    begin
                        ok_next  = 1'b1;
                        inv_next = pos_reg ? cc_reg : (modulus_reg - cc_reg);
                    end
                    else
                    begin
                        ok_next  = 1'b0;
                        inv_next = '0;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                ovalid_next = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ovalid_reg  <= 1'b0;
            modulus_reg <= {{(WordW-1){1'b0}}, 1'b1};
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            if (cfg_valid && cfg_ready)
            begin
                modulus_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rp_reg  <= rp_next;
        rc_reg  <= rc_next;
        cp_reg  <= cp_next;
        cc_reg  <= cc_next;
        pos_reg <= pos_next;
        inv_reg <= inv_next;
        ok_reg  <= ok_next;
    end

    assign result_valid = ovalid_reg;
    assign inverse      = inv_reg;
    assign invertible   = ok_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !value_ready)
        else $error("value accepted while busy");
    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !invertible) |-> (inverse == '0))
        else $error("non-invertible result carries nonzero inverse");
    a_inv_range: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && invertible) |-> (inverse < modulus_reg))
        else $error("inverse not reduced");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(inverse)))
        else $error("result dropped");
endmodule
`default_nettype wire

@@ hw/rtl/minv_divmul.sv @@
`default_nettype none
// Restoring divider producing the remainder of a by b, developing one quotient
// bit per cycle. Alongside each quotient bit it accumulates c + q * d by
// shift-and-add, so the cofactor update needs no multiplier.
module minv_divmul
    import minv_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [WordW-1:0] a,
    input  wire logic [WordW-1:0] b,
    input  wire logic [WordW-1:0] c,
    input  wire logic [WordW-1:0] d,
    output logic                  done,
    output logic [WordW-1:0]      rem,
    output logic [WordW-1:0]      acc
);
    logic [WordW-1:0] quo_reg, quo_next;
    logic [WordW-1:0] rem_reg, rem_next;
    logic [WordW-1:0] acc_reg, acc_next;
    logic [WordW-1:0] b_reg, d_reg, c_reg;
    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [WordW:0]   shifted;
    logic [WordW:0]   diff;
    logic             qbit;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[WordW-1]};
        diff      = shifted - {1'b0, b_reg};
        qbit      = ~diff[WordW];
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = a;
            rem_next  = '0;
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[WordW-2:0], 1'b0};
            rem_next = qbit ? diff[WordW-1:0] : shifted[WordW-1:0];
            acc_next = {acc_reg[WordW-2:0], 1'b0} + (qbit ? d_reg : '0);
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CntW'(WordW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        acc_reg <= acc_next;
        if (start)
        begin
            b_reg <= b;
            c_reg <= c;
            d_reg <= d;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;
    assign acc  = acc_reg + c_reg;
endmodule
`default_nettype wire

@@ tb/sv/tb_modular_inverse_euclid.sv @@
`timescale 1ns / 1ps
module tb_modular_inverse_euclid;
    import minv_pkg::*;

    localparam int unsigned StallLimit = 20000;
    localparam int unsigned DrainCycles = 7000;

    typedef struct packed {
        logic [WordW-1:0] inverse;
        logic             invertible;
    } inv_result_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [WordW-1:0] cfg_data;
    logic             value_valid;
    logic             value_ready;
    logic [WordW-1:0] value;
    logic             result_valid;
    logic             result_ready;
    logic [WordW-1:0] inverse;
    logic             invertible;

    logic [WordW-1:0] cur_modulus;
    inv_result_t      pending_inverses[$];
    int unsigned      error_count;
    int unsigned      idle_cycles;
    bit               quiet_mode;

    modular_inverse_euclid dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .value_valid  (value_valid),
        .value_ready  (value_ready),
        .value        (value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .inverse      (inverse),
        .invertible   (invertible)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic inv_result_t predict_inverse(logic [WordW-1:0] v, logic [WordW-1:0] m);
        logic [WordW-1:0] rp;
        logic [WordW-1:0] rc;
        logic [WordW-1:0] rn;
        logic [WordW-1:0] q;
        logic [WordW-1:0] cp;
        logic [WordW-1:0] cc;
        logic [WordW-1:0] cn;
        bit               pos;
        inv_result_t      r;
        r = '0;
        if (v == 0 || v >= m)
            return r;
        rp = m;
        rc = v;
        cp = 0;
        cc = 1;
        pos = 1'b1;
        forever
        begin
            q = rp / rc;
            rn = rp - q * rc;
            if (rn == 0)
                break;
            cn = cp + q * cc;
            rp = rc;
            rc = rn;
            cp = cc;
            cc = cn;
            pos = !pos;
        end
        if (rc != 1)
            return r;
        r.inverse = pos ? cc : (m - cc);
        r.invertible = 1'b1;
        return r;
    endfunction

    function automatic logic [WordW-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    task automatic random_gap();
        if (!quiet_mode && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 10)) @(posedge clk);
    endtask

    task automatic send_value(logic [WordW-1:0] v);
        random_gap();
        value_valid <= 1'b1;
        value <= v;
        pending_inverses.push_back(predict_inverse(v, cur_modulus));
        do
            @(posedge clk);
        while (!value_ready);
        value_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_inverses.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_modulus(logic [WordW-1:0] m);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_modulus = m;
    endtask

    task automatic test_reset_modulus();
        send_value(0);
        send_value(1);
        send_value('1);
    endtask

    task automatic test_directed();
        write_modulus(64'd97);
        send_value(0);
        send_value(1);
        send_value(96);
        send_value(97);
        send_value(50);
        write_modulus(64'd12);
        send_value(4);
        send_value(5);
        send_value(11);
        write_modulus('1);
        send_value(1);
        send_value(64'hFFFF_FFFF_FFFF_FFFE);
        send_value('1);
        send_value(3);
        send_value(64'h8000_0000_0000_0000);
        write_modulus(64'h8000_0000_0000_0000);
        send_value(64'h7FFF_FFFF_FFFF_FFFF);
        send_value(64'h5555_5555_5555_5555);
        write_modulus(0);
        send_value(0);
        send_value(5);
        write_modulus(1);
        send_value(0);
    endtask

    task automatic test_random(int unsigned count);
        logic [WordW-1:0] v;
        for (int unsigned i = 0; i < count; i++)
        begin
            if (i % 250 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: write_modulus(rand_word() | 64'h1);
                    1: write_modulus(rand_word());
                    2: write_modulus({32'd0, $urandom()});
                    default: write_modulus(64'hFFFF_FFFF_FFFF_FFC5);
                endcase
            end
            if (i == count - 100)
                quiet_mode = 1'b1;
            if ($urandom_range(0, 19) == 0)
                v = rand_word();
            else if (cur_modulus > 1)
                v = rand_word() % cur_modulus;
            else
                v = rand_word();
            send_value(v);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        value_valid = 1'b0;
        value = '0;
        cur_modulus = 64'd1;
        error_count = 0;
        quiet_mode = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_modulus();
        test_directed();
        test_random(1500);
        wait_drained();
        if (error_count == 0)
            $display("modular_inverse_euclid test passed");
        else
            $display("modular_inverse_euclid test failed");
        $finish;
    end

    initial
    begin
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!quiet_mode && $urandom_range(0, 3) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            result_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        inv_result_t exp_r;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_inverses.size() == 0)
            begin
                $error("result beat with no pending value");
                error_count++;
            end
            else
            begin
                exp_r = pending_inverses.pop_front();
                if (inverse !== exp_r.inverse)
                begin
                    $error("inverse expected %h actual %h", exp_r.inverse, inverse);
                    error_count++;
                end
                if (invertible !== exp_r.invertible)
                begin
                    $error("invertible expected %b actual %b", exp_r.invertible, invertible);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((value_valid && value_ready) || (result_valid && result_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit)
        begin
            $display("modular_inverse_euclid test failed");
            $finish;
        end
    end
endmodule

@@ sim.f @@
hw/rtl/minv_pkg.sv
hw/rtl/minv_divmul.sv
hw/rtl/modular_inverse_euclid.sv
tb/sv/tb_modular_inverse_euclid.sv
